/* rtl/core/dme_pkg.sv */
// Shared types, constants and hash step function for the minimizer extractor.
`timescale 1ns / 1ps

package dme_pkg;

	localparam int KMER_BITS_DEF  = 38;
	localparam int WINDOW_LEN_DEF = 16;
	localparam int HASH_W         = 64;
	localparam int MIN_HASH_W     = 38;
	localparam int COUNT_W        = 32;
	localparam int BASE_W         = 8;

	// complement of a 2-bit base code
	localparam logic [1:0] COMP_XOR = 2'b10;

	// mix shift amounts
	localparam int SH_A_ADD = 21;
	localparam int SH_A_XOR = 24;
	localparam int SH_B_LO  = 3;
	localparam int SH_B_HI  = 8;
	localparam int SH_B_XOR = 14;
	localparam int SH_C_LO  = 2;
	localparam int SH_C_HI  = 4;
	localparam int SH_C_XOR = 28;
	localparam int SH_D_ADD = 31;

	typedef struct packed {
		logic [BASE_W-1:0] base;
		logic              last_base;
	} in_word_t;

	typedef struct packed {
		logic [MIN_HASH_W-1:0] minimizer_hash;
		logic                  has_minimizer;
		logic                  sequence_end;
		logic [COUNT_W-1:0]    minimizer_count;
	} out_word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CANON,
		ST_MIX,
		ST_WRITE,
		ST_SCAN,
		ST_DECIDE
	} state_t;

	// each mix step is one add chain followed by its xor-shift, except MIX_D, which is the add chain alone
	typedef enum logic [1:0] {
		MIX_A,
		MIX_B,
		MIX_C,
		MIX_D
	} mix_step_t;

	typedef struct packed {
		logic      accept;
		logic      hash_load;
		logic      mix_en;
		mix_step_t mix_step;
		logic      win_write;
		logic      scan_en;
		logic      commit;
	} dp_cmd_t;

	typedef struct packed {
		logic kmer_full;
		logic win_fill;
		logic scan_last;
		logic need_result;
		logic out_busy;
	} dp_status_t;

	function automatic logic [HASH_W-1:0] mix_step(input logic [HASH_W-1:0] k,
			input mix_step_t step);
		logic [HASH_W-1:0] t;
		logic [HASH_W-1:0] r;
		t = '0;
		r = '0;
		case (step)
			MIX_A: begin
				t = ~k + (k << SH_A_ADD);
				r = t ^ (t >> SH_A_XOR);
			end
			MIX_B: begin
				t = k + (k << SH_B_LO) + (k << SH_B_HI);
				r = t ^ (t >> SH_B_XOR);
			end
			MIX_C: begin
				t = k + (k << SH_C_LO) + (k << SH_C_HI);
				r = t ^ (t >> SH_C_XOR);
			end
			MIX_D: begin
				r = k + (k << SH_D_ADD);
			end
			default: begin
				r = k;
			end
		endcase
		return r;
	endfunction

endpackage

/* rtl/core/dme_ctrl.sv */
// Sequencing state machine for the minimizer extractor.
`timescale 1ns / 1ps

module dme_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                base_valid,
	output logic                base_stall,
	input  dme_pkg::dp_status_t status,
	output dme_pkg::dp_cmd_t    cmd
);
	import dme_pkg::*;

	state_t    state_q, state_d;
	mix_step_t step_q, step_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= MIX_A;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		step_d       = step_q;
		cmd          = '0;
		cmd.mix_step = step_q;
		base_stall   = 1'b1;
		case (state_q)
			ST_IDLE: begin
				base_stall = 1'b0;
				if (base_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_CANON;
				end
			end
			ST_CANON: begin
				if (status.kmer_full) begin
					cmd.hash_load = 1'b1;
					step_d        = MIX_A;
					state_d       = ST_MIX;
				end else begin
					state_d = ST_DECIDE;
				end
			end
			ST_MIX: begin
				cmd.mix_en = 1'b1;
				case (step_q)
					MIX_A:   step_d = MIX_B;
					MIX_B:   step_d = MIX_C;
					MIX_C:   step_d = MIX_D;
					default: begin
						step_d  = MIX_A;
						state_d = ST_WRITE;
					end
				endcase
			end
			ST_WRITE: begin
				cmd.win_write = 1'b1;
				state_d       = status.win_fill ? ST_SCAN : ST_DECIDE;
			end
			ST_SCAN: begin
				cmd.scan_en = 1'b1;
				if (status.scan_last) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				// hold while a result is needed and the output word is still stalled
				if (!status.need_result || !status.out_busy) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

/* rtl/core/dme_datapath.sv */
// K-mer registers, hash unit, hash window, minimum scan and output register.
`timescale 1ns / 1ps

module dme_datapath #(
	parameter int KMER_BITS  = dme_pkg::KMER_BITS_DEF,
	parameter int WINDOW_LEN = dme_pkg::WINDOW_LEN_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  dme_pkg::in_word_t   base_word,
	input  logic                min_stall,
	output logic                min_valid,
	output dme_pkg::out_word_t  min_word,
	input  dme_pkg::dp_cmd_t    cmd,
	output dme_pkg::dp_status_t status
);
	import dme_pkg::*;

	localparam int KMER_BASES = KMER_BITS / 2;
	localparam int BS_W       = $clog2(KMER_BASES + 1);
	localparam int HS_W       = $clog2(WINDOW_LEN + 1);
	localparam int PTR_W      = $clog2(WINDOW_LEN);

	logic [KMER_BITS-1:0] fwd_q, rev_q;
	logic [BS_W-1:0]      bases_q;
	logic                 last_q;
	logic [HASH_W-1:0]    hash_q;
	logic [KMER_BITS-1:0] win_mem [WINDOW_LEN];
	logic [PTR_W-1:0]     wptr_q;
	logic [HS_W-1:0]      hashes_q;
	logic [PTR_W-1:0]     scan_q;
	logic [KMER_BITS-1:0] min_q;
	logic                 min_ok_q;
	logic [KMER_BITS-1:0] last_em_q;
	logic                 any_q;
	logic [COUNT_W-1:0]   count_q;
	logic                 out_valid_q;
	out_word_t            out_word_q;

	logic [1:0]           code;
	logic [KMER_BITS-1:0] canon;
	logic                 scan_last;
	logic                 emit;
	logic [COUNT_W-1:0]   count_next;
	logic [HASH_W-1:0]    min_ext;

	assign code      = base_word.base[2:1];
	assign canon     = (fwd_q < rev_q) ? fwd_q : rev_q;
	assign scan_last = (scan_q == PTR_W'(WINDOW_LEN - 1));
	assign emit      = min_ok_q && (!any_q || (min_q != last_em_q));
	assign count_next = (emit && (count_q != '1)) ? count_q + COUNT_W'(1) : count_q;
	assign min_ext   = HASH_W'(min_q);

	assign status.kmer_full   = (bases_q == BS_W'(KMER_BASES));
	assign status.win_fill    = (hashes_q >= HS_W'(WINDOW_LEN - 1));
	assign status.scan_last   = scan_last;
	assign status.need_result = emit || last_q;
	assign status.out_busy    = out_valid_q && min_stall;

	assign min_valid = out_valid_q;
	assign min_word  = out_word_q;

	// k-mer shift registers and sequence bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q     <= '0;
			rev_q     <= '0;
			bases_q   <= '0;
			last_q    <= 1'b0;
			wptr_q    <= '0;
			hashes_q  <= '0;
			last_em_q <= '0;
			any_q     <= 1'b0;
			count_q   <= '0;
		end else begin
			if (cmd.accept) begin
				fwd_q  <= {fwd_q[KMER_BITS-3:0], code};
				rev_q  <= {code ^ COMP_XOR, rev_q[KMER_BITS-1:2]};
				last_q <= base_word.last_base;
				if (bases_q != BS_W'(KMER_BASES)) begin
					bases_q <= bases_q + BS_W'(1);
				end
			end
			if (cmd.win_write) begin
				wptr_q <= (wptr_q == PTR_W'(WINDOW_LEN - 1)) ? '0 : wptr_q + PTR_W'(1);
				if (hashes_q != HS_W'(WINDOW_LEN)) begin
					hashes_q <= hashes_q + HS_W'(1);
				end
			end
			if (cmd.commit) begin
				if (last_q) begin
					fwd_q     <= '0;
					rev_q     <= '0;
					bases_q   <= '0;
					wptr_q    <= '0;
					hashes_q  <= '0;
					last_em_q <= '0;
					any_q     <= 1'b0;
					count_q   <= '0;
				end else if (emit) begin
					last_em_q <= min_q;
					any_q     <= 1'b1;
					count_q   <= count_next;
				end
			end
		end
	end

	// hash register: load canonical k-mer, then one mix step per cycle
	always_ff @(posedge clk) begin
		if (cmd.hash_load) begin
			hash_q <= HASH_W'(canon);
		end else if (cmd.mix_en) begin
			hash_q <= mix_step(hash_q, cmd.mix_step);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.win_write) begin
			win_mem[wptr_q] <= hash_q[KMER_BITS-1:0];
		end
	end

	// window minimum, one entry per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q   <= '0;
			min_ok_q <= 1'b0;
		end else begin
			if (cmd.accept) begin
				scan_q   <= '0;
				min_ok_q <= 1'b0;
			end else if (cmd.scan_en) begin
				scan_q <= scan_last ? '0 : scan_q + PTR_W'(1);
				if (scan_last) begin
					min_ok_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_en) begin
			if ((scan_q == '0) || (win_mem[scan_q] < min_q)) begin
				min_q <= win_mem[scan_q];
			end
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit && (emit || last_q)) begin
			out_valid_q <= 1'b1;
		end else if (!min_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && (emit || last_q)) begin
			out_word_q.minimizer_hash  <= emit ? min_ext[MIN_HASH_W-1:0] : '0;
			out_word_q.has_minimizer   <= emit;
			out_word_q.sequence_end    <= last_q;
			out_word_q.minimizer_count <= count_next;
		end
	end

endmodule

/* rtl/core/dna_minimizer_extractor.sv */
// Top level of the canonical k-mer minimizer extractor: controller plus datapath.
// Sequence: a base is accepted in IDLE, then passes CANON, the mix steps, WRITE, the window
// scan and DECIDE; before the k-mer fills it skips the hash and write, before the window fills the scan.
// One base is processed at a time: the next is accepted only after DECIDE commits, which it
// does while a finished word waits on min_stall unless the new base needs a result word too.
// Reset: arst_n clears k-mers, counters and valid flags; the hash window is not cleared.
`timescale 1ns / 1ps

module dna_minimizer_extractor #(
	parameter int KMER_BITS  = dme_pkg::KMER_BITS_DEF,
	parameter int WINDOW_LEN = dme_pkg::WINDOW_LEN_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               base_valid,
	output logic               base_stall,
	input  dme_pkg::in_word_t  base_word,
	output logic               min_valid,
	input  logic               min_stall,
	output dme_pkg::out_word_t min_word
);
	import dme_pkg::*;

	// Command and status between the sequencer and the datapath. The sequencer walks
	// IDLE -> CANON -> MIX (4 steps) -> WRITE -> SCAN (WINDOW_LEN entries) -> DECIDE,
	// skipping the hash when the k-mer is not yet full and the scan when the window
	// is not yet full.
	dp_cmd_t    cmd;
	dp_status_t status;

	dme_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.base_valid (base_valid),
		.base_stall (base_stall),
		.status     (status),
		.cmd        (cmd)
	);

	// Datapath holds the k-mers, the window store, the running minimum and the
	// output word register; a closing base clears the sequence state on commit.
	dme_datapath #(
		.KMER_BITS  (KMER_BITS),
		.WINDOW_LEN (WINDOW_LEN)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.base_word (base_word),
		.min_stall (min_stall),
		.min_valid (min_valid),
		.min_word  (min_word),
		.cmd       (cmd),
		.status    (status)
	);

endmodule

/* tb/sv/dna_minimizer_extractor_tb.sv */
// Self-checking testbench for the canonical k-mer minimizer extractor.
`timescale 1ns / 1ps

module dna_minimizer_extractor_tb;

	import dme_pkg::*;

	localparam int KMER_BITS   = KMER_BITS_DEF;
	localparam int KMER_BASES  = KMER_BITS / 2;
	localparam int WIN         = WINDOW_LEN_DEF;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int HOLD_CYCLES = 600;
	localparam int DRAIN_WAIT  = 60;
	localparam int PHASE_ITEMS = 290;

	// A C G T a c g t
	localparam logic [7:0] NUCLEOTIDES [8] = '{8'h41, 8'h43, 8'h47, 8'h54,
		8'h61, 8'h63, 8'h67, 8'h74};

	// opening words: byte extremes, every letter in both cases, odd bit patterns
	localparam logic [7:0] DIRECTED_BASES [15] = '{8'h00,
		8'hFF, 8'h41, 8'h43, 8'h47, 8'h54, 8'h61, 8'h63, 8'h67, 8'h74,
		8'h55, 8'hAA,
		8'h80, 8'h7F, 8'h01};
	localparam logic [14:0] DIRECTED_LAST = 15'b100101000000001;

	typedef enum int {
		SEQ_RANDOM,
		SEQ_REPEAT,
		SEQ_SHORT,
		SEQ_JUNK
	} seq_kind_t;

	// predictor plus queue of expected output words
	class minimizer_scoreboard;
		logic [KMER_BITS-1:0]  fwd_kmer;
		logic [KMER_BITS-1:0]  rev_kmer;
		int unsigned           kmer_fill;
		logic [MIN_HASH_W-1:0] hash_ring [WIN];
		int unsigned           ring_ptr;
		int unsigned           ring_fill;
		logic [MIN_HASH_W-1:0] prev_min;
		bit                    min_seen;
		logic [COUNT_W-1:0]    min_count;
		out_word_t             expected_q [$];
		int unsigned           errors;

		function new();
			errors = 0;
			clear_sequence();
		endfunction

		function void clear_sequence();
			fwd_kmer  = '0;
			rev_kmer  = '0;
			kmer_fill = 0;
			ring_ptr  = 0;
			ring_fill = 0;
			prev_min  = '0;
			min_seen  = 1'b0;
			min_count = '0;
		endfunction

		// 64-bit shift/add/xor mix, cut to the hash width
		function logic [MIN_HASH_W-1:0] kmer_hash(input logic [63:0] key);
			logic [63:0] k;
			k = key;
			k = ~k + (k << 21);
			k = k ^ (k >> 24);
			k = k + (k << 3) + (k << 8);
			k = k ^ (k >> 14);
			k = k + (k << 2) + (k << 4);
			k = k ^ (k >> 28);
			k = k + (k << 31);
			return k[MIN_HASH_W-1:0];
		endfunction

		function void note_base(input in_word_t w);
			logic [1:0]            code;
			logic [KMER_BITS-1:0]  canon;
			logic [MIN_HASH_W-1:0] win_min;
			bit                    emit;
			out_word_t             exp_word;
			code     = w.base[2:1];
			emit     = 1'b0;
			win_min  = '0;
			fwd_kmer = {fwd_kmer[KMER_BITS-3:0], code};
			rev_kmer = {code ^ COMP_XOR, rev_kmer[KMER_BITS-1:2]};
			if (kmer_fill < KMER_BASES)
				kmer_fill++;
			if (kmer_fill == KMER_BASES) begin
				canon = (fwd_kmer < rev_kmer) ? fwd_kmer : rev_kmer;
				hash_ring[ring_ptr] = kmer_hash({{(64-KMER_BITS){1'b0}}, canon});
				ring_ptr = (ring_ptr + 1) % WIN;
				if (ring_fill < WIN)
					ring_fill++;
				// window full: min over all entries, emit only on change
				if (ring_fill == WIN) begin
					win_min = hash_ring[0];
					for (int i = 1; i < WIN; i++)
						if (hash_ring[i] < win_min)
							win_min = hash_ring[i];
					if (!min_seen || win_min != prev_min) begin
						emit     = 1'b1;
						prev_min = win_min;
						min_seen = 1'b1;
						if (min_count != '1)
							min_count++;
					end
				end
			end
			if (emit || w.last_base) begin
				exp_word.minimizer_hash  = emit ? win_min : '0;
				exp_word.has_minimizer   = emit;
				exp_word.sequence_end    = w.last_base;
				exp_word.minimizer_count = min_count;
				expected_q = {expected_q, exp_word};
			end
			if (w.last_base)
				clear_sequence();
		endfunction

		function void report_field(input string name, input logic [63:0] want,
				input logic [63:0] got);
			if (want !== got) begin
				$display("%0t: %s mismatch, expected %0h, actual %0h",
					$time, name, want, got);
				errors++;
			end
		endfunction

		function void check_word(input out_word_t got);
			out_word_t want;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected output word, expected none, actual %h",
					$time, got);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			report_field("minimizer_hash", want.minimizer_hash, got.minimizer_hash);
			report_field("has_minimizer", want.has_minimizer, got.has_minimizer);
			report_field("sequence_end", want.sequence_end, got.sequence_end);
			report_field("minimizer_count", want.minimizer_count, got.minimizer_count);
		endfunction
	endclass

	logic      clk;
	logic      arst_n;
	logic      base_valid;
	logic      base_stall;
	in_word_t  base_word;
	logic      min_valid;
	logic      min_stall;
	out_word_t min_word;

	minimizer_scoreboard sb = new();

	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	int unsigned hold_armed;
	int unsigned items_sent;
	int unsigned cycle_count;

	dna_minimizer_extractor u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.base_valid(base_valid),
		.base_stall(base_stall),
		.base_word (base_word),
		.min_valid (min_valid),
		.min_stall (min_stall),
		.min_word  (min_word)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// both sides sampled at the rising edge, inputs moved at the falling edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (base_valid && !base_stall)
				sb.note_base(base_word);
			if (min_valid && !min_stall)
				sb.check_word(min_word);
		end
	end

	// receiver: random stalls, plus a long hold-off whenever one is armed
	initial begin
		int unsigned hold_seen;
		int unsigned hold_left;
		hold_seen = 0;
		hold_left = 0;
		min_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				min_stall <= 1'b1;
				hold_left--;
			end else if (hold_armed != hold_seen) begin
				hold_seen = hold_armed;
				hold_left = HOLD_CYCLES - 1;
				min_stall <= 1'b1;
			end else begin
				min_stall <= ($urandom_range(0, 99) < recv_stall_pct);
			end
		end
	end

	function automatic logic [7:0] pick_base(input int unsigned junk_pct);
		if ($urandom_range(0, 99) < junk_pct)
			return 8'($urandom_range(0, 255));
		return NUCLEOTIDES[$urandom_range(0, 7)];
	endfunction

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_base(input in_word_t w);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			base_valid <= 1'b0;
			@(negedge clk);
		end
		base_valid <= 1'b1;
		base_word  <= w;
		do
			@(posedge clk);
		while (base_stall);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_sequence(input seq_kind_t kind);
		int unsigned len;
		int unsigned period;
		logic [7:0]  motif [4];
		in_word_t    w;
		period = $urandom_range(1, 4);
		for (int j = 0; j < 4; j++)
			motif[j] = pick_base(0);
		case (kind)
			SEQ_RANDOM: len = $urandom_range(KMER_BASES + WIN - 1, 160);
			SEQ_REPEAT: len = $urandom_range(KMER_BASES + WIN - 1, 120);
			SEQ_SHORT:  len = $urandom_range(1, KMER_BASES + WIN - 2);
			default:    len = $urandom_range(20, 80);
		endcase
		for (int i = 0; i < len; i++) begin
			case (kind)
				SEQ_RANDOM: w.base = pick_base(5);
				// low-complexity runs repeat the same minimizer; rare point changes
				SEQ_REPEAT: w.base = ($urandom_range(0, 99) < 3) ? pick_base(0)
					: motif[i % period];
				SEQ_SHORT:  w.base = pick_base(10);
				default:    w.base = 8'($urandom_range(0, 255));
			endcase
			w.last_base = (i == len - 1);
			send_base(w);
		end
	endtask

	task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct);
		int unsigned target;
		int unsigned pick;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		target = items_sent + PHASE_ITEMS;
		while (items_sent < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 65)
				send_sequence(SEQ_RANDOM);
			else if (pick < 80)
				send_sequence(SEQ_REPEAT);
			else if (pick < 90)
				send_sequence(SEQ_SHORT);
			else
				send_sequence(SEQ_JUNK);
		end
	endtask

	initial begin
		in_word_t w;
		arst_n         = 1'b0;
		base_valid     = 1'b0;
		base_word      = '0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_armed     = 0;
		items_sent     = 0;
		cycle_count    = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed words: single-base sequence, all letters, byte extremes
		for (int i = 0; i < 15; i++) begin
			w.base      = DIRECTED_BASES[i];
			w.last_base = DIRECTED_LAST[i];
			send_base(w);
		end

		run_phase(0, 0);
		run_phase(79, 0);
		run_phase(0, 79);
		run_phase(27, 27);
		// long receiver hold-off while the sender keeps offering words
		hold_armed++;
		run_phase(0, 0);

		base_valid <= 1'b0;
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (sb.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
